>>> hdl/nearest_point_on_segments_macros.svh
// ----------------------------------------------------------------------------
// nearest point on segments: assertion macros
// shared forms for the concurrent checks, sampled on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef NEAREST_POINT_ON_SEGMENTS_MACROS_SVH
`define NEAREST_POINT_ON_SEGMENTS_MACROS_SVH

// same-cycle implication
`define NPS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// default widths shared by the channel interfaces and the datapath
// ----------------------------------------------------------------------------
package nps_pkg;

	localparam int COORD_BITS_DEF = 18;
	localparam int FRAC_BITS_DEF  = 16;

endpackage

>>> hdl/nps_in_if.sv
// ----------------------------------------------------------------------------
// nps_in_if
// segment channel: query point, segment endpoints and run flags
// ----------------------------------------------------------------------------
interface nps_in_if #(
	parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] query_x;
	logic signed [COORD_BITS-1:0] query_y;
	logic signed [COORD_BITS-1:0] seg_start_x;
	logic signed [COORD_BITS-1:0] seg_start_y;
	logic signed [COORD_BITS-1:0] seg_end_x;
	logic signed [COORD_BITS-1:0] seg_end_y;
	logic                         endpoints_known;
	logic                         last_segment;

	modport source (
		output valid, query_x, query_y, seg_start_x, seg_start_y,
		       seg_end_x, seg_end_y, endpoints_known, last_segment,
		input  ready
	);

	modport sink (
		input  valid, query_x, query_y, seg_start_x, seg_start_y,
		       seg_end_x, seg_end_y, endpoints_known, last_segment,
		output ready
	);
endinterface

>>> hdl/nps_out_if.sv
// ----------------------------------------------------------------------------
// nps_out_if
// result channel: nearest point and found flag
// ----------------------------------------------------------------------------
interface nps_out_if #(
	parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] nearest_x;
	logic signed [COORD_BITS-1:0] nearest_y;
	logic                         segment_found;

	modport source (
		output valid, nearest_x, nearest_y, segment_found,
		input  ready
	);

	modport sink (
		input  valid, nearest_x, nearest_y, segment_found,
		output ready
	);
endinterface

>>> hdl/nearest_point_on_segments.sv
// ----------------------------------------------------------------------------
// nearest_point_on_segments
// projects a query onto a run of segments and reports the closest point
// ----------------------------------------------------------------------------
// One segment item is taken at a time; ready stays low until it is done.
// A skipped segment (unknown endpoints) goes straight to the final step, a
// zero-length one stops once length and numerator are formed, a clamped one
// goes on to the distance, and one that needs the projection parameter (Q0.16
// at the default) also runs the bit-per-cycle restoring divider and makes
// the eight passes through the single shared multiplier. On the last segment
// of a run the result goes into an output register, so the next run can start
// while it waits to be taken; the block only holds in its final step if an
// earlier result is still waiting. Ties keep the earlier segment.
// ----------------------------------------------------------------------------
`include "nearest_point_on_segments_macros.svh"

module nearest_point_on_segments #(
	parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = nps_pkg::FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	nps_in_if.sink    seg_in,
	nps_out_if.source nearest_out
);

	localparam int CW     = COORD_BITS;
	localparam int DW     = CW + 1;
	localparam int PCW    = CW + 2;
	localparam int MW     = (CW + 2 > FRAC_BITS + 1) ? CW + 2 : FRAC_BITS + 1;
	localparam int PW     = 2 * MW;
	localparam int LEN_W  = 2 * CW + 2;
	localparam int NUM_W  = 2 * CW + 3;
	localparam int DIST_W = 2 * CW + 2;
	localparam int CNT_W  = $clog2(FRAC_BITS);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LEN0 = 4'd1;
	localparam logic [3:0] S_LEN1 = 4'd2;
	localparam logic [3:0] S_NUM0 = 4'd3;
	localparam logic [3:0] S_NUM1 = 4'd4;
	localparam logic [3:0] S_NUMS = 4'd5;
	localparam logic [3:0] S_CLS  = 4'd6;
	localparam logic [3:0] S_DIV  = 4'd7;
	localparam logic [3:0] S_PX   = 4'd8;
	localparam logic [3:0] S_PY   = 4'd9;
	localparam logic [3:0] S_PYW  = 4'd10;
	localparam logic [3:0] S_D0   = 4'd11;
	localparam logic [3:0] S_D1   = 4'd12;
	localparam logic [3:0] S_D2   = 4'd13;
	localparam logic [3:0] S_UPD  = 4'd14;
	localparam logic [3:0] S_FIN  = 4'd15;

	logic [3:0] state_q;

	logic signed [CW-1:0]  qx_q, qy_q, ax_q, ay_q, bx_q, by_q;
	logic                  last_q;
	logic signed [DW-1:0]  dx_q, dy_q, ux_q, uy_q;
	logic [LEN_W-1:0]      len_q;
	logic signed [NUM_W-1:0] num_q;
	logic [NUM_W-1:0]      rem_q;
	logic [FRAC_BITS-1:0]  quo_q;
	logic [CNT_W-1:0]      cnt_q;
	logic signed [PCW-1:0] px_q, py_q;
	logic [DIST_W-1:0]     dist_q;
	logic [DIST_W-1:0]     least_q;
	logic signed [CW-1:0]  best_x_q, best_y_q;
	logic                  any_found_q;

	logic                  out_valid_q;
	logic signed [CW-1:0]  out_x_q, out_y_q;
	logic                  out_found_q;

	logic                  mul_en;
	logic signed [MW-1:0]  mul_a, mul_b;
	logic signed [PW-1:0]  prod_q;

	logic signed [PCW-1:0] ex, ey;
	logic [NUM_W-1:0]      rem_sh;
	logic [NUM_W-1:0]      len_ext;
	logic signed [PCW-1:0] rnd_pt;
	logic                  out_load;
	logic                  accept;

	// round half toward +infinity after dropping the fraction bits
	function automatic logic signed [PCW-1:0] scale_round(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] w;
		w = v + (PW'(1) <<< (FRAC_BITS - 1));
		return PCW'(w >>> FRAC_BITS);
	endfunction

	assign accept         = seg_in.valid && seg_in.ready;
	assign seg_in.ready   = (state_q == S_IDLE);
	assign ex             = px_q - PCW'(qx_q);
	assign ey             = py_q - PCW'(qy_q);
	assign len_ext        = NUM_W'(len_q);
	assign rem_sh         = {rem_q[NUM_W-2:0], 1'b0};
	assign out_load       = (state_q == S_FIN) && last_q && (!out_valid_q || nearest_out.ready);

	// the adder for the projected point follows the rounded product
	always_comb begin
		rnd_pt = scale_round(prod_q);
	end

	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			S_LEN0: begin
				mul_a = MW'(dx_q);
				mul_b = MW'(dx_q);
			end
			S_LEN1: begin
				mul_a = MW'(dy_q);
				mul_b = MW'(dy_q);
			end
			S_NUM0: begin
				mul_a = MW'(ux_q);
				mul_b = MW'(dx_q);
			end
			S_NUM1: begin
				mul_a = MW'(uy_q);
				mul_b = MW'(dy_q);
			end
			S_PX: begin
				mul_a = MW'({1'b0, quo_q});
				mul_b = MW'(dx_q);
			end
			S_PY: begin
				mul_a = MW'({1'b0, quo_q});
				mul_b = MW'(dy_q);
			end
			S_D0: begin
				mul_a = MW'(ex);
				mul_b = MW'(ex);
			end
			S_D1: begin
				mul_a = MW'(ey);
				mul_b = MW'(ey);
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	nps_mul #(
		.MW (MW)
	) u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	// item fields and working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					qx_q    <= seg_in.query_x;
					qy_q    <= seg_in.query_y;
					ax_q    <= seg_in.seg_start_x;
					ay_q    <= seg_in.seg_start_y;
					bx_q    <= seg_in.seg_end_x;
					by_q    <= seg_in.seg_end_y;
					last_q  <= seg_in.last_segment;
					dx_q    <= DW'(seg_in.seg_end_x) - DW'(seg_in.seg_start_x);
					dy_q    <= DW'(seg_in.seg_end_y) - DW'(seg_in.seg_start_y);
					ux_q    <= DW'(seg_in.query_x) - DW'(seg_in.seg_start_x);
					uy_q    <= DW'(seg_in.query_y) - DW'(seg_in.seg_start_y);
				end
			end
			S_LEN1: len_q <= LEN_W'(prod_q);
			S_NUM0: len_q <= len_q + LEN_W'(prod_q);
			S_NUM1: num_q <= NUM_W'(prod_q);
			S_NUMS: num_q <= num_q + NUM_W'(prod_q);
			S_CLS: begin
				rem_q <= NUM_W'(num_q);
				quo_q <= '0;
				cnt_q <= '0;
				if (num_q <= 0) begin
					px_q <= PCW'(ax_q);
					py_q <= PCW'(ay_q);
				end else begin
					px_q <= PCW'(bx_q);
					py_q <= PCW'(by_q);
				end
			end
			S_DIV: begin
				cnt_q <= cnt_q + 1'b1;
				if (rem_sh >= len_ext) begin
					rem_q <= rem_sh - len_ext;
					quo_q <= {quo_q[FRAC_BITS-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[FRAC_BITS-2:0], 1'b0};
				end
			end
			S_PY:  px_q <= PCW'(ax_q) + rnd_pt;
			S_PYW: py_q <= PCW'(ay_q) + rnd_pt;
			S_D1:  dist_q <= DIST_W'(prod_q);
			S_D2:  dist_q <= dist_q + DIST_W'(prod_q);
			default: begin
			end
		endcase
	end

	// sequencer and run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			least_q     <= '1;
			best_x_q    <= '0;
			best_y_q    <= '0;
			any_found_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= seg_in.endpoints_known ? S_LEN0 : S_FIN;
					end
				end
				S_LEN0: state_q <= S_LEN1;
				S_LEN1: state_q <= S_NUM0;
				S_NUM0: state_q <= S_NUM1;
				S_NUM1: state_q <= S_NUMS;
				S_NUMS: state_q <= S_CLS;
				S_CLS: begin
					if (len_q == '0) begin
						state_q <= S_FIN;
					end else if (num_q <= 0 || num_q >= signed'(len_ext)) begin
						state_q <= S_D0;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (cnt_q == CNT_W'(FRAC_BITS - 1)) begin
						state_q <= S_PX;
					end
				end
				S_PX:  state_q <= S_PY;
				S_PY:  state_q <= S_PYW;
				S_PYW: state_q <= S_D0;
				S_D0:  state_q <= S_D1;
				S_D1:  state_q <= S_D2;
				S_D2:  state_q <= S_UPD;
				S_UPD: begin
					if (dist_q < least_q) begin
						least_q     <= dist_q;
						best_x_q    <= CW'(px_q);
						best_y_q    <= CW'(py_q);
						any_found_q <= 1'b1;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (out_load) begin
						least_q     <= '1;
						best_x_q    <= '0;
						best_y_q    <= '0;
						any_found_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (nearest_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q     <= any_found_q ? best_x_q : qx_q;
			out_y_q     <= any_found_q ? best_y_q : qy_q;
			out_found_q <= any_found_q;
		end
	end

	assign nearest_out.valid         = out_valid_q;
	assign nearest_out.nearest_x     = out_x_q;
	assign nearest_out.nearest_y     = out_y_q;
	assign nearest_out.segment_found = out_found_q;

	`NPS_ASSERT_NEXT(a_busy_after_accept, accept, !seg_in.ready, "ready high right after an item")
	`NPS_ASSERT_NOW(a_empty_run_is_inf, !any_found_q, least_q == '1, "best distance set with no segment")
	`NPS_ASSERT_NOW(a_cleared_on_result, $rose(nearest_out.valid), !any_found_q && state_q == S_IDLE, "run state not cleared on result")

endmodule

>>> hdl/nps_mul.sv
// ----------------------------------------------------------------------------
// nps_mul
// shared signed multiplier with a registered product
// ----------------------------------------------------------------------------
module nps_mul #(
	parameter int MW = nps_pkg::COORD_BITS_DEF + 2
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [MW-1:0]   a,
	input  logic signed [MW-1:0]   b,
	output logic signed [2*MW-1:0] p_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= a * b;
		end
	end

endmodule
